[hw/rtl/lcs_pkg.sv]
// ============================================================================
// lcs_pkg
// Shared types and constants of the least-loaded CPU selector: field widths,
// result status codes, controller states and the controller/datapath bundles.
// ============================================================================
package lcs_pkg;

  // Fixed field widths of the item and result ports
  localparam int MaskW   = 16;
  localparam int CpuIdW  = 4;
  localparam int LoadW   = 12;
  localparam int StatusW = 3;

  // Defaults of the top-level parameters
  localparam int DefaultNumCpus   = 16;
  localparam int DefaultCountBits = 12;

  // Reset value of the online mask register: every CPU online
  localparam logic [MaskW-1:0] OnlineReset = 16'hFFFF;

  // Item function code
  typedef enum logic {
    FUNC_REQUEST = 1'b0,
    FUNC_RELEASE = 1'b1
  } func_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK       = 3'd0,
    ST_FALLBACK = 3'd1,
    ST_NONE     = 3'd2,
    ST_SAT      = 3'd3,
    ST_UNDER    = 3'd4
  } status_e;

  // How an item gets its target CPU once decoded
  typedef enum logic [1:0] {
    PATH_NONE   = 2'd0,  // no counter touched, answer at once
    PATH_DIRECT = 2'd1,  // target known, read-modify-write it
    PATH_SCAN   = 2'd2   // search the masked online counters first
  } path_e;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_DECODE = 3'd1,
    S_SCAN   = 3'd2,
    S_TAIL   = 3'd3,
    S_READ   = 3'd4,
    S_UPDATE = 3'd5
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;    // latch the accepted item
    logic decide;     // register the decode result, restart the scan
    logic emit_none;  // answer without touching any counter
    logic scan_rd;    // read the counter at the scan index
    logic take_best;  // make the scan winner the target
    logic rd_tgt;     // read the target counter
    logic commit;     // update the target counter and load the result
  } ctl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    path_e path;
    logic  scan_last;
  } dp_sts_t;

endpackage

[hw/rtl/lcs_ctrl.sv]
// ============================================================================
// lcs_ctrl
// Sequencer of the selector: takes one item at a time, steps it through
// decode and, if it touches a counter, an optional scan, a read and an update of the counter.
// ============================================================================
module lcs_ctrl
  import lcs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  dp_sts_t  sts_i,
  output ctl_cmd_t cmd_o,
  output logic     busy_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.decide = 1'b1;
        case (sts_i.path)
          PATH_NONE: begin
            cmd_o.emit_none = 1'b1;
            state_d         = S_IDLE;
          end
          PATH_DIRECT: state_d = S_READ;
          PATH_SCAN:   state_d = S_SCAN;
          default:     state_d = S_IDLE;
        endcase
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_TAIL;
        end
      end
      S_TAIL: begin
        // last compare lands here; winner becomes the target
        cmd_o.take_best = 1'b1;
        state_d         = S_READ;
      end
      S_READ: begin
        cmd_o.rd_tgt = 1'b1;
        state_d      = S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.commit = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

[hw/rtl/lcs_datapath.sv]
// ============================================================================
// lcs_datapath
// Load counter memory, online mask register, item decode, the sequential
// least-loaded scan and the counter update with its result registers.
// ============================================================================
module lcs_datapath
  import lcs_pkg::*;
#(
  parameter int NUM_CPUS   = DefaultNumCpus,
  parameter int COUNT_BITS = DefaultCountBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctl_cmd_t            cmd_i,
  output dp_sts_t             sts_o,
  input  logic                func_i,
  input  logic [MaskW-1:0]    cpu_set_i,
  input  logic [CpuIdW-1:0]   release_cpu_i,
  input  logic                cfg_wr_i,
  input  logic [MaskW-1:0]    cfg_online_mask_i,
  output logic                done_o,
  output logic [CpuIdW-1:0]   chosen_cpu_o,
  output logic [StatusW-1:0]  status_o,
  output logic [LoadW-1:0]    new_load_o
);

  localparam int IdxW     = $clog2(NUM_CPUS);
  // only the CPUs that a 16-bit mask can name take part in a scan
  localparam int ScanN    = (NUM_CPUS < MaskW) ? NUM_CPUS : MaskW;
  localparam int ScanIdxW = $clog2(ScanN);
  localparam logic [MaskW:0] CpuMaskW = (MaskW+1)'((1 << ScanN) - 1);
  localparam logic [MaskW-1:0] CpuMask = CpuMaskW[MaskW-1:0];
  localparam logic [COUNT_BITS-1:0] CntMax = '1;

  // Lowest set bit of a mask, zero for an empty mask
  function automatic logic [CpuIdW-1:0] first_bit(input logic [MaskW-1:0] m);
    logic [CpuIdW-1:0] r;
    r = '0;
    for (int i = MaskW - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = CpuIdW'(i);
      end
    end
    return r;
  endfunction

  // Online mask register
  logic [MaskW-1:0] online_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      online_q <= OnlineReset;
    end else if (cfg_wr_i) begin
      online_q <= cfg_online_mask_i;
    end
  end

  // Captured item
  logic              func_q;
  logic [MaskW-1:0]  req_q;
  logic [CpuIdW-1:0] rel_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      req_q  <= cpu_set_i;
      rel_q  <= release_cpu_i;
    end
  end

  // Decode
  logic [MaskW-1:0]  req_m, on_m, cand;
  path_e             path;
  logic [IdxW-1:0]   dec_tgt;
  status_e           dec_st;
  logic [CpuIdW-1:0] none_cpu;

  assign req_m = req_q & CpuMask;
  assign on_m  = online_q & CpuMask;
  assign cand  = req_m & on_m;

  always_comb begin
    path     = PATH_NONE;
    dec_tgt  = '0;
    dec_st   = ST_OK;
    none_cpu = '0;
    if (func_q == FUNC_RELEASE) begin
      if (int'(rel_q) >= NUM_CPUS) begin
        none_cpu = rel_q;
      end else begin
        path    = PATH_DIRECT;
        dec_tgt = IdxW'(rel_q);
      end
    end else if (req_m == '0) begin
      path = PATH_NONE;
    end else if ((req_m & (req_m - 1'b1)) == '0) begin
      // single CPU asked for: taken as given, online or not
      path    = PATH_DIRECT;
      dec_tgt = IdxW'(first_bit(req_m));
    end else if (cand == '0) begin
      if (on_m != '0) begin
        path    = PATH_DIRECT;
        dec_tgt = IdxW'(first_bit(on_m));
        dec_st  = ST_FALLBACK;
      end
    end else begin
      path = PATH_SCAN;
    end
  end

  // Scan index
  logic [ScanIdxW-1:0] scan_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
    end else if (cmd_i.decide) begin
      scan_idx_q <= '0;
    end else if (cmd_i.scan_rd) begin
      scan_idx_q <= ScanIdxW'(scan_idx_q + 1'b1);
    end
  end

  assign sts_o.path      = path;
  assign sts_o.scan_last = (scan_idx_q == ScanIdxW'(ScanN - 1));

  // Load counter memory, one read port with registered data
  logic [COUNT_BITS-1:0] mem_q [NUM_CPUS];
  logic [NUM_CPUS-1:0]   vld_q;
  logic [COUNT_BITS-1:0] rd_data_q;
  logic                  rd_vld_q;
  logic                  rd_en;
  logic [IdxW-1:0]       rd_addr;
  logic [IdxW-1:0]       tgt_q;
  logic                  wr_en;
  logic [COUNT_BITS-1:0] wr_data;

  assign rd_en   = cmd_i.scan_rd | cmd_i.rd_tgt;
  assign rd_addr = cmd_i.scan_rd ? IdxW'(scan_idx_q) : tgt_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[tgt_q] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
      rd_vld_q  <= vld_q[rd_addr];
    end
  end

  // Entry valid bits: a never-written counter reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[tgt_q] <= 1'b1;
    end
  end

  logic [COUNT_BITS-1:0] rd_cnt;
  assign rd_cnt = rd_vld_q ? rd_data_q : '0;

  // Scan compare, one counter per cycle, strict less keeps the lowest index
  logic                  cmp_vld_q;
  logic [ScanIdxW-1:0]   cmp_idx_q;
  logic                  found_q, found_d;
  logic [ScanIdxW-1:0]   best_idx_q, best_idx_d;
  logic [COUNT_BITS-1:0] best_cnt_q, best_cnt_d;
  logic [ScanN-1:0]      cand_s;

  assign cand_s = cand[ScanN-1:0];

  always_comb begin
    found_d    = found_q;
    best_idx_d = best_idx_q;
    best_cnt_d = best_cnt_q;
    if (cmp_vld_q && cand_s[cmp_idx_q] && (!found_q || (rd_cnt < best_cnt_q))) begin
      found_d    = 1'b1;
      best_idx_d = cmp_idx_q;
      best_cnt_d = rd_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_vld_q <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.scan_rd;
      found_q   <= cmd_i.decide ? 1'b0 : found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= scan_idx_q;
    best_idx_q <= best_idx_d;
    best_cnt_q <= best_cnt_d;
  end

  // Target and pending status
  status_e st_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      tgt_q <= dec_tgt;
      st_q  <= dec_st;
    end else if (cmd_i.take_best) begin
      tgt_q <= IdxW'(best_idx_d);
    end
  end

  // Counter update
  logic    at_floor, at_max;
  status_e upd_st;
  logic [COUNT_BITS-1:0] upd_load;

  assign at_floor = (rd_cnt == '0);
  assign at_max   = (rd_cnt == CntMax);

  always_comb begin
    wr_data  = rd_cnt;
    upd_st   = st_q;
    upd_load = rd_cnt;
    wr_en    = 1'b0;
    if (func_q == FUNC_RELEASE) begin
      if (at_floor) begin
        upd_st = ST_UNDER;
      end else begin
        wr_data  = rd_cnt - 1'b1;
        upd_load = wr_data;
        wr_en    = cmd_i.commit;
      end
    end else begin
      if (at_max) begin
        upd_st = ST_SAT;
      end else begin
        wr_data  = rd_cnt + 1'b1;
        upd_load = wr_data;
        wr_en    = cmd_i.commit;
      end
    end
  end

  // Result registers and strobe
  logic              done_q;
  logic [CpuIdW-1:0] res_cpu_q;
  status_e           res_st_q;
  logic [LoadW-1:0]  res_load_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.commit | cmd_i.emit_none;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_none) begin
      res_cpu_q  <= none_cpu;
      res_st_q   <= ST_NONE;
      res_load_q <= '0;
    end else if (cmd_i.commit) begin
      res_cpu_q  <= (func_q == FUNC_RELEASE) ? rel_q : CpuIdW'(tgt_q);
      res_st_q   <= upd_st;
      res_load_q <= LoadW'(upd_load);
    end
  end

  assign done_o       = done_q;
  assign chosen_cpu_o = res_cpu_q;
  assign status_o     = res_st_q;
  assign new_load_o   = res_load_q;

endmodule

[hw/rtl/least_loaded_cpu_selector.sv]
// ============================================================================
// least_loaded_cpu_selector
// Picks the least-loaded online CPU out of a requested set and keeps one
// saturating load counter per CPU; releases count a CPU's load back down.
// ============================================================================
// Usage:
//   Items enter on start/busy: an item (func_i, cpu_set_i, release_cpu_i) is
//   taken at a clock edge where start is high and busy is low. One item is
//   worked on at a time. Every item gives exactly one result, shown on
//   chosen_cpu_o, status_o and new_load_o for a single cycle while done_o is
//   high. The receiver cannot hold results off; the result registers keep the
//   last result until the next one.
//   The online mask is written over cfg_valid_i / cfg_ready_o; ready is
//   always high, and the mask should change only while the block is idle.
//   How an item is handled once it is accepted:
//     an item that touches no counter is answered straight from decode,
//     a release, a single-CPU request or a fallback reads and updates its
//     counter, and a multi-CPU request first scans ScanN counters, where
//     ScanN = min(NUM_CPUS, 16); the scan reads one counter per cycle
//     through the single read port of the counter memory.
//   The done strobe comes when busy is already low, and another item can be
//   taken in that same cycle. Reset clears all counters (through per-entry
//   valid bits) and sets every CPU online.
// ============================================================================
module least_loaded_cpu_selector
  import lcs_pkg::*;
#(
  parameter int NUM_CPUS   = DefaultNumCpus,
  parameter int COUNT_BITS = DefaultCountBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               func_i,
  input  logic [MaskW-1:0]   cpu_set_i,
  input  logic [CpuIdW-1:0]  release_cpu_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [MaskW-1:0]   cfg_online_mask_i,
  output logic               done_o,
  output logic [CpuIdW-1:0]  chosen_cpu_o,
  output logic [StatusW-1:0] status_o,
  output logic [LoadW-1:0]   new_load_o
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // Configuration is always taken
  assign cfg_ready_o = 1'b1;

  // Sequencer
  lcs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // Counters, scan and result
  lcs_datapath #(
    .NUM_CPUS   (NUM_CPUS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .func_i            (func_i),
    .cpu_set_i         (cpu_set_i),
    .release_cpu_i     (release_cpu_i),
    .cfg_wr_i          (cfg_valid_i & cfg_ready_o),
    .cfg_online_mask_i (cfg_online_mask_i),
    .done_o            (done_o),
    .chosen_cpu_o      (chosen_cpu_o),
    .status_o          (status_o),
    .new_load_o        (new_load_o)
  );

  // An accepted item keeps the block busy in the next cycle
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting an item");

  // A result only follows work in progress
  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without an item in flight");

  // A result never overlaps the handling of an item
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // No-CPU and underflow results report a zero load
  a_zero_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_NONE || status_o == ST_UNDER)) |-> (new_load_o == '0))
    else $error("nonzero load on a no-CPU or underflow result");

endmodule
